// ===== design/sf_dial_pulse_digit_decoder_assert.svh =====
// Assertion helpers shared by the decoder modules.
// Each expects clk and rst in scope and checks only outside reset.
`ifndef SF_DIAL_PULSE_DIGIT_DECODER_ASSERT_SVH
`define SF_DIAL_PULSE_DIGIT_DECODER_ASSERT_SVH

// Same-cycle implication.
`define SFDP_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdp: same-cycle check failed");

// Next-cycle implication.
`define SFDP_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdp: next-cycle check failed");

`endif

// ===== design/sfdp_pkg.sv =====
`timescale 1ns / 1ps

package sfdp_pkg;

  // Payload of one input transaction
  typedef struct packed {
    logic       tone_hit;
    logic [9:0] elapsed_ms;
    logic       restart;
  } in_t;

  // Payload of one result transaction
  typedef struct packed {
    logic       digit_valid;
    logic [6:0] digit_char;
    logic       done_res;
    logic [1:0] end_status;
  } out_t;

  // Configuration register contents
  typedef struct packed {
    logic [7:0]  max_digits;
    logic        extra_pulses;
    logic [31:0] timeout_ms;
    logic [9:0]  min_off_ms;
    logic [9:0]  off_window_ms;
    logic [11:0] digit_gap_ms;
  } cfg_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_MAX_DIGITS    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_EXTRA_PULSES  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_MS    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_OFF_MS    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFF_WINDOW_MS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DIGIT_GAP_MS  = 3'd5;

  // Register reset values
  localparam logic [9:0]  MIN_OFF_RST    = 10'd25;
  localparam logic [9:0]  OFF_WINDOW_RST = 10'd30;
  localparam logic [11:0] DIGIT_GAP_RST  = 12'd600;

  // End status codes
  localparam logic [1:0] ST_RUNNING    = 2'd0;
  localparam logic [1:0] ST_MAX_DIGITS = 2'd1;
  localparam logic [1:0] ST_TIMEOUT    = 2'd2;
  localparam logic [1:0] ST_STORE_FULL = 2'd3;

  // Digit characters
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_HASH  = 7'h23;
  localparam logic [6:0] CH_D     = 7'h44;
  localparam logic [6:0] CH_C     = 7'h43;
  localparam logic [6:0] CH_B     = 7'h42;
  localparam logic [6:0] CH_A     = 7'h41;

  localparam logic [5:0] PULSE_MAX = 6'd63;

  // Pulse count to ASCII digit character, or to *, #, D, C, B, A for 11 and more pulses when extra is set
  function automatic logic [6:0] map_digit(input logic [5:0] n, input logic extra);
    logic [6:0] ch;
    if (n <= 6'd9) begin
      ch = CH_ZERO + 7'(n);
    end else if (n == 6'd10 || !extra) begin
      ch = CH_ZERO;
    end else begin
      priority case (n)
        6'd11:   ch = CH_STAR;
        6'd12:   ch = CH_HASH;
        6'd13:   ch = CH_D;
        6'd14:   ch = CH_C;
        6'd15:   ch = CH_B;
        default: ch = CH_A;
      endcase
    end
    return ch;
  endfunction

endpackage

// ===== design/sfdp_cfg_regs.sv =====
`timescale 1ns / 1ps

module sfdp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [sfdp_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [sfdp_pkg::CfgDataW-1:0] wr_data,
  output sfdp_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_digits    <= '0;
      cfg.extra_pulses  <= 1'b0;
      cfg.timeout_ms    <= '0;
      cfg.min_off_ms    <= sfdp_pkg::MIN_OFF_RST;
      cfg.off_window_ms <= sfdp_pkg::OFF_WINDOW_RST;
      cfg.digit_gap_ms  <= sfdp_pkg::DIGIT_GAP_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        sfdp_pkg::REG_MAX_DIGITS:    cfg.max_digits    <= wr_data[7:0];
        sfdp_pkg::REG_EXTRA_PULSES:  cfg.extra_pulses  <= wr_data[0];
        sfdp_pkg::REG_TIMEOUT_MS:    cfg.timeout_ms    <= wr_data[31:0];
        sfdp_pkg::REG_MIN_OFF_MS:    cfg.min_off_ms    <= wr_data[9:0];
        sfdp_pkg::REG_OFF_WINDOW_MS: cfg.off_window_ms <= wr_data[9:0];
        sfdp_pkg::REG_DIGIT_GAP_MS:  cfg.digit_gap_ms  <= wr_data[11:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

endmodule

// ===== design/sfdp_engine.sv =====
`timescale 1ns / 1ps

module sfdp_engine #(
  parameter int unsigned STORE_DIGITS = 255
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  sfdp_pkg::in_t  item,
  input  sfdp_pkg::cfg_t cfg,
  output sfdp_pkg::out_t result
);

  localparam logic [7:0] StoreLim = 8'(STORE_DIGITS);

  logic        tone_on, tone_on_next;
  logic [9:0]  pulse_timer, pulse_timer_next;
  logic [11:0] gap_timer, gap_timer_next;
  logic [31:0] total_timer, total_timer_next;
  logic [5:0]  pulse_count, pulse_count_next;
  logic [7:0]  digit_count, digit_count_next;
  logic        finished, finished_next;
  logic [1:0]  final_status, final_status_next;

  logic [10:0] pt_sum;
  logic [12:0] gt_sum;
  logic [32:0] tt_sum;
  logic [9:0]  pt_sat;
  logic [11:0] gt_sat;
  logic [31:0] tt_sat;
  logic [9:0]  off_excess;
  logic        dig_valid;
  logic [6:0]  dig_char;

  always_comb begin
    pt_sum = {1'b0, pulse_timer} + 11'(item.elapsed_ms);
    gt_sum = {1'b0, gap_timer} + 13'(item.elapsed_ms);
    tt_sum = {1'b0, total_timer} + 33'(item.elapsed_ms);
    pt_sat = pt_sum[10] ? '1 : pt_sum[9:0];
    gt_sat = gt_sum[12] ? '1 : gt_sum[11:0];
    tt_sat = tt_sum[32] ? '1 : tt_sum[31:0];
    off_excess = pt_sat - cfg.min_off_ms;

    tone_on_next      = tone_on;
    pulse_timer_next  = pulse_timer;
    gap_timer_next    = gap_timer;
    total_timer_next  = total_timer;
    pulse_count_next  = pulse_count;
    digit_count_next  = digit_count;
    finished_next     = finished;
    final_status_next = final_status;
    dig_valid         = 1'b0;
    dig_char          = '0;

    if (item.restart) begin
      tone_on_next      = 1'b0;
      pulse_timer_next  = '0;
      gap_timer_next    = '0;
      total_timer_next  = '0;
      pulse_count_next  = '0;
      digit_count_next  = '0;
      finished_next     = 1'b0;
      final_status_next = sfdp_pkg::ST_RUNNING;
    end else if (!finished) begin
      pulse_timer_next = pt_sat;
      gap_timer_next   = gt_sat;
      total_timer_next = tt_sat;
      if (cfg.timeout_ms != '0 && tt_sat >= cfg.timeout_ms) begin
        finished_next     = 1'b1;
        final_status_next = sfdp_pkg::ST_TIMEOUT;
      end else if (digit_count >= StoreLim) begin
        finished_next     = 1'b1;
        final_status_next = sfdp_pkg::ST_STORE_FULL;
      end else if (item.tone_hit) begin
        tone_on_next     = 1'b1;
        pulse_timer_next = '0;
      end else if (tone_on) begin
        if (pt_sat >= cfg.min_off_ms) begin
          tone_on_next = 1'b0;
          if (off_excess < cfg.off_window_ms) begin
            if (pulse_count != sfdp_pkg::PULSE_MAX) begin
              pulse_count_next = pulse_count + 6'd1;
            end
            gap_timer_next = '0;
          end
        end
      end else if (pulse_count != '0 && gt_sat >= cfg.digit_gap_ms) begin
        dig_valid        = 1'b1;
        dig_char         = sfdp_pkg::map_digit(pulse_count, cfg.extra_pulses);
        pulse_count_next = '0;
        if (digit_count != 8'hFF) begin
          digit_count_next = digit_count + 8'd1;
        end
        if (cfg.max_digits != '0 && digit_count_next >= cfg.max_digits) begin
          finished_next     = 1'b1;
          final_status_next = sfdp_pkg::ST_MAX_DIGITS;
        end
      end
    end

    result.digit_valid = dig_valid;
    result.digit_char  = dig_char;
    result.done_res    = finished_next;
    result.end_status  = final_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_on      <= 1'b0;
      pulse_timer  <= '0;
      gap_timer    <= '0;
      total_timer  <= '0;
      pulse_count  <= '0;
      digit_count  <= '0;
      finished     <= 1'b0;
      final_status <= sfdp_pkg::ST_RUNNING;
    end else if (step) begin
      tone_on      <= tone_on_next;
      pulse_timer  <= pulse_timer_next;
      gap_timer    <= gap_timer_next;
      total_timer  <= total_timer_next;
      pulse_count  <= pulse_count_next;
      digit_count  <= digit_count_next;
      finished     <= finished_next;
      final_status <= final_status_next;
    end
  end

`include "sf_dial_pulse_digit_decoder_assert.svh"

  `SFDP_AST_IMP(a_fin_status, finished, final_status != sfdp_pkg::ST_RUNNING)
  `SFDP_AST_NXT(a_restart_clears, step && item.restart, ~|{finished, pulse_count, digit_count})
  `SFDP_AST_NXT(a_hold_when_done, !step, $stable(digit_count) && $stable(finished))

endmodule

// ===== design/sfdp_outbuf.sv =====
`timescale 1ns / 1ps

module sfdp_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfdp_pkg::out_t push_data,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output sfdp_pkg::out_t out_data
);

  logic           skid_valid;
  sfdp_pkg::out_t skid_data;
  logic           pop;

  assign pop   = out_valid & out_ready;
  assign space = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= push;
    end else if (push && out_valid) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      out_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

`include "sf_dial_pulse_digit_decoder_assert.svh"

  `SFDP_AST_IMP(a_skid_under_main, skid_valid, out_valid)
  `SFDP_AST_NXT(a_skid_drains, pop && skid_valid, out_valid && !skid_valid)
  `SFDP_AST_IMP(a_no_push_when_full, skid_valid, !push)

endmodule

// ===== design/sf_dial_pulse_digit_decoder.sv =====
`timescale 1ns / 1ps

// Single-frequency dial pulse receiver. Each input transaction is one audio-frame
// report (tone detector hit, ms since the previous frame, restart) and yields exactly
// one result transaction: a digit strobe with its ASCII character, plus the done flag
// and end status (running, max digits, timeout, store full). Throughput is one item
// per clock: the timer, pulse and digit update is a single pass of compares and
// saturating adds from the accepted input into the state and result registers, so
// an item is accepted every cycle that the two-entry output buffer has room. The
// result is registered in the output buffer. Configuration registers (index 0
// max_digits, 1 extra_pulses, 2 timeout_ms, 3 min_off_ms, 4 off_window_ms,
// 5 digit_gap_ms) are written through the cfg channel, which is always ready; write
// only while no items are in flight. STORE_DIGITS (1..255) sets the digit count at
// which reception ends with store-full status.
module sf_dial_pulse_digit_decoder #(
  parameter int unsigned STORE_DIGITS = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  // frame reports
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfdp_pkg::in_t                 in_data,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfdp_pkg::out_t                out_data,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfdp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sfdp_pkg::CfgDataW-1:0] cfg_data
);

  sfdp_pkg::cfg_t cfg;
  sfdp_pkg::out_t result;
  logic           step;
  logic           space;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  // One transaction per cycle whenever the skid slot is free.
  assign in_ready = space;
  assign step     = in_valid & in_ready;

  sfdp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Timers, pulse/digit counters and end status; result is combinational
  // on the accepted frame and is captured by the output buffer.
  sfdp_engine #(
    .STORE_DIGITS (STORE_DIGITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // Output register plus skid entry, so back-pressure on the result side
  // does not drop a transaction already in flight.
  sfdp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
